// ===== src/assert_macros.svh =====
// shared assertion macros, clocked on clk with the active-low reset masking them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define B64_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be true outside reset
`define B64_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== src/b64_pkg.sv =====
package b64_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_DIRECTION = 2'd0;
  localparam logic [1:0] REG_CHAR_62   = 2'd1;
  localparam logic [1:0] REG_CHAR_63   = 2'd2;
  localparam logic [1:0] REG_PAD_CHAR  = 2'd3;

  localparam logic [7:0] CHAR_62_RST  = 8'd43;
  localparam logic [7:0] CHAR_63_RST  = 8'd47;
  localparam logic [7:0] PAD_CHAR_RST = 8'd61;

  localparam logic [5:0] SIX_MASK = 6'h3F;
  localparam logic [6:0] PAD_IDX  = 7'd64;
  localparam logic [6:0] BAD_IDX  = 7'd65;

  localparam int unsigned JOB_DEPTH = 4;

  typedef enum logic [1:0] {
    JOB_ENC = 2'd0,
    JOB_DEC = 2'd1,
    JOB_ERR = 2'd2
  } job_kind_t;

  // one finished group handed from the front end to the output sequencer
  typedef struct packed {
    job_kind_t   kind;
    logic [23:0] word;   // group bits, first output in the top bits
    logic [1:0]  n;      // encode: bytes in group; decode: bytes to emit
    logic        last;
  } job_t;

endpackage

// ===== src/b64_fifo.sv =====
`include "assert_macros.svh"

module b64_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  b64_pkg::job_t push_job,
  input  logic          pop,
  output b64_pkg::job_t pop_job,
  output logic          full,
  output logic          not_empty
);
  import b64_pkg::*;

  localparam int unsigned AW = $clog2(JOB_DEPTH);

  job_t            mem_r [JOB_DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]     cnt_r, cnt_nxt;

  assign full      = (cnt_r == (AW+1)'(JOB_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  `B64_NEVER(a_no_push_full, push && full && !pop, "job pushed into full queue")
  `B64_NEVER(a_no_pop_empty, pop && !not_empty, "job popped from empty queue")

endmodule

// ===== src/b64_front.sv =====
module b64_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  input  logic          direction,
  input  logic          dir_write,
  input  logic [7:0]    char_62,
  input  logic [7:0]    char_63,
  input  logic [7:0]    pad_char,
  output logic          push,
  output b64_pkg::job_t job
);
  import b64_pkg::*;

  logic [23:0] bits_r, bits_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [1:0]  pads_r, pads_nxt;
  logic        skip_r, skip_nxt;

  logic [6:0]  idx;
  logic [5:0]  six;
  logic [1:0]  n;
  logic [1:0]  pads_new;
  logic [23:0] enc_bits;
  logic [23:0] dec_bits;
  logic        err;

  // alphabet lookup, first match wins
  always_comb begin
    if (in_byte >= 8'd65 && in_byte <= 8'd90) begin
      idx = 7'(in_byte - 8'd65);
    end else if (in_byte >= 8'd97 && in_byte <= 8'd122) begin
      idx = 7'(in_byte - 8'd71);
    end else if (in_byte >= 8'd48 && in_byte <= 8'd57) begin
      idx = 7'(in_byte + 8'd4);
    end else if (in_byte == char_62) begin
      idx = 7'd62;
    end else if (in_byte == char_63) begin
      idx = 7'd63;
    end else if (in_byte == pad_char) begin
      idx = PAD_IDX;
    end else begin
      idx = BAD_IDX;
    end
  end

  always_comb begin
    bits_nxt = bits_r;
    cnt_nxt  = cnt_r;
    pads_nxt = pads_r;
    skip_nxt = skip_r;
    push     = 1'b0;
    job      = '{kind: JOB_ENC, word: '0, n: '0, last: in_last};
    n        = cnt_r + 2'd1;
    enc_bits = {bits_r[15:0], in_byte};
    six      = '0;
    pads_new = pads_r;
    err      = 1'b0;
    dec_bits = '0;

    if (accept) begin
      if (skip_r) begin
        if (in_last) begin
          skip_nxt = 1'b0;
        end
      end else if (!direction) begin
        bits_nxt = enc_bits;
        if (n != 2'd3 && !in_last) begin
          cnt_nxt = n;
        end else begin
          push     = 1'b1;
          job.kind = JOB_ENC;
          job.n    = n;
          case (n)
            2'd1:    job.word = {enc_bits[7:0], 16'h0};
            2'd2:    job.word = {enc_bits[15:0], 8'h0};
            default: job.word = enc_bits;
          endcase
          bits_nxt = '0;
          cnt_nxt  = '0;
          pads_nxt = '0;
        end
      end else begin
        if (idx == BAD_IDX) begin
          err = 1'b1;
        end else if (idx == PAD_IDX) begin
          if (cnt_r < 2'd2) begin
            err = 1'b1;
          end else begin
            pads_new = pads_r + 2'd1;
          end
        end else if (pads_r != 2'd0) begin
          err = 1'b1;
        end else begin
          six = idx[5:0] & SIX_MASK;
        end
        dec_bits = {bits_r[17:0], six};
        if (!err) begin
          if (cnt_r != 2'd3) begin
            if (in_last) begin
              err = 1'b1;
            end else begin
              bits_nxt = dec_bits;
              cnt_nxt  = cnt_r + 2'd1;
              pads_nxt = pads_new;
            end
          end else begin
            push     = 1'b1;
            job.kind = JOB_DEC;
            job.word = dec_bits;
            job.n    = 2'd3 - pads_new;
            bits_nxt = '0;
            cnt_nxt  = '0;
            pads_nxt = '0;
          end
        end
        if (err) begin
          push     = 1'b1;
          job.kind = JOB_ERR;
          job.n    = 2'd1;
          bits_nxt = '0;
          cnt_nxt  = '0;
          pads_nxt = '0;
          skip_nxt = !in_last;
        end
      end
      if (in_last) begin
        bits_nxt = '0;
        cnt_nxt  = '0;
        pads_nxt = '0;
      end
    end

    if (dir_write) begin
      bits_nxt = '0;
      cnt_nxt  = '0;
      pads_nxt = '0;
      skip_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= '0;
      cnt_r  <= '0;
      pads_r <= '0;
      skip_r <= 1'b0;
    end else begin
      bits_r <= bits_nxt;
      cnt_r  <= cnt_nxt;
      pads_r <= pads_nxt;
      skip_r <= skip_nxt;
    end
  end

endmodule

// ===== src/b64_back.sv =====
`include "assert_macros.svh"

module b64_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_avail,
  input  b64_pkg::job_t job,
  output logic          job_pop,
  input  logic [7:0]    char_62,
  input  logic [7:0]    char_63,
  input  logic [7:0]    pad_char,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_tdata,
  output logic          out_tlast,
  output logic          out_tuser
);
  import b64_pkg::*;

  function automatic logic [7:0] symbol_of(input logic [5:0] v, input logic [7:0] c62,
                                           input logic [7:0] c63);
    logic [7:0] s;
    if (v < 6'd26) begin
      s = 8'd65 + 8'(v);
    end else if (v < 6'd52) begin
      s = 8'd71 + 8'(v);
    end else if (v < 6'd62) begin
      s = 8'(v) - 8'd4;
    end else if (v == 6'd62) begin
      s = c62;
    end else begin
      s = c63;
    end
    return s;
  endfunction

  logic        busy_r;
  job_kind_t   kind_r;
  logic [23:0] word_r, word_nxt;
  logic [1:0]  n_r;
  logic        last_r;
  logic [1:0]  k_r;

  logic        vld_r;
  logic [7:0]  data_r, data_nxt;
  logic        olast_r;
  logic        oerr_r, oerr_nxt;

  logic        adv;
  logic        final_k;
  logic [1:0]  last_k;

  assign adv     = busy_r && (!vld_r || out_tready);
  assign final_k = (k_r == last_k);
  assign job_pop = job_avail && (!busy_r || (adv && final_k));

  always_comb begin
    last_k   = '0;
    data_nxt = '0;
    oerr_nxt = 1'b0;
    word_nxt = word_r;
    unique case (kind_r)
      JOB_ENC: begin
        last_k   = 2'd3;
        data_nxt = (k_r <= n_r) ? symbol_of(word_r[23:18], char_62, char_63) : pad_char;
        word_nxt = {word_r[17:0], 6'h0};
      end
      JOB_DEC: begin
        last_k   = n_r - 2'd1;
        data_nxt = word_r[23:16];
        word_nxt = {word_r[15:0], 8'h0};
      end
      default: begin
        oerr_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      vld_r  <= 1'b0;
      k_r    <= '0;
    end else begin
      if (job_pop) begin
        busy_r <= 1'b1;
        k_r    <= '0;
      end else if (adv && final_k) begin
        busy_r <= 1'b0;
      end else if (adv) begin
        k_r <= k_r + 2'd1;
      end
      if (adv) begin
        vld_r <= 1'b1;
      end else if (out_tready) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      kind_r <= job.kind;
      word_r <= job.word;
      n_r    <= job.n;
      last_r <= job.last;
    end else if (adv) begin
      word_r <= word_nxt;
    end
    if (adv) begin
      data_r  <= data_nxt;
      olast_r <= final_k && last_r;
      oerr_r  <= oerr_nxt;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = oerr_r;

  `B64_ASSERT(a_err_zero, vld_r && oerr_r |-> data_r == 8'h00, "error result with nonzero byte")
  `B64_NEVER(a_dec_empty, busy_r && kind_r == JOB_DEC && n_r == 2'd0, "decode job with no bytes")

endmodule

// ===== src/base64_stream_codec.sv =====
// base64 codec: front end gathers groups, a four-entry job queue, output sequencer
// a completed group is written into the job queue, then loaded into the output sequencer
// throughput: one result per cycle while out_tready is high; encode is paced by the output
// sequencer; front end takes one decode character per cycle while the job queue has room
// reset: synchronous active-low rst_n clears group state, queue and output valid, and sets
// the registers to encode mode with '+', '/' and '=' symbols
module base64_stream_codec (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,
  output logic       out_tuser,  // [0] out_error
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import b64_pkg::*;

  logic       dir_r;
  logic [7:0] c62_r;
  logic [7:0] c63_r;
  logic [7:0] pad_r;
  logic       cfg_wr;
  logic       dir_write;

  logic       accept;
  logic       push;
  job_t       push_job;
  logic       pop;
  job_t       pop_job;
  logic       full;
  logic       not_empty;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign dir_write = cfg_wr && (cfg_index == REG_DIRECTION);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= 1'b0;
      c62_r <= CHAR_62_RST;
      c63_r <= CHAR_63_RST;
      pad_r <= PAD_CHAR_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_DIRECTION: dir_r <= cfg_data[0];
        REG_CHAR_62:   c62_r <= cfg_data;
        REG_CHAR_63:   c63_r <= cfg_data;
        REG_PAD_CHAR:  pad_r <= cfg_data;
        default:       dir_r <= dir_r;
      endcase
    end
  end

  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  b64_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .direction (dir_r),
    .dir_write (dir_write),
    .char_62   (c62_r),
    .char_63   (c63_r),
    .pad_char  (pad_r),
    .push      (push),
    .job       (push_job)
  );

  b64_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .pop_job   (pop_job),
    .full      (full),
    .not_empty (not_empty)
  );

  b64_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_avail  (not_empty),
    .job        (pop_job),
    .job_pop    (pop),
    .char_62    (c62_r),
    .char_63    (c63_r),
    .pad_char   (pad_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== tb/tb_base64_stream_codec.sv =====
`timescale 1ns / 1ps

module tb_base64_stream_codec;
  import b64_pkg::*;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam int RX_ALWAYS   = 0;
  localparam int RX_RANDOM   = 1;
  localparam int RX_PERIODIC = 2;

  localparam int SETTLE_CYCLES = 8;
  localparam int ITEMS_PER_PHASE = 10;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] in_byte
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [7:0] out_byte
  logic       out_tlast;
  logic       out_tuser;  // [0] out_error
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  base64_stream_codec dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } codec_out_t;

  codec_out_t expected_out_q[$];

  // codec state as the block should hold it
  logic        mdl_dir;
  logic [7:0]  mdl_c62;
  logic [7:0]  mdl_c63;
  logic [7:0]  mdl_pad;
  logic [23:0] grp_bits;
  logic [1:0]  grp_cnt;
  logic [1:0]  grp_pads;
  logic        grp_skip;

  int fail_count    = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int cfg_writes    = 0;
  int burst_left    = 0;
  int tx_gap_max    = 0;
  int rx_mode       = RX_ALWAYS;
  int rx_tick       = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results still expected", expected_out_q.size());
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------- predictor ----------------

  function automatic logic [7:0] six_to_char(logic [5:0] v);
    if (v < 6'd26) return 8'h41 + {2'b00, v};
    if (v < 6'd52) return 8'h61 + {2'b00, v} - 8'd26;
    if (v < 6'd62) return 8'h30 + {2'b00, v} - 8'd52;
    if (v == 6'd62) return mdl_c62;
    return mdl_c63;
  endfunction

  // first match wins: letters, digits, then the three registers in order
  function automatic logic [6:0] char_to_six(logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) return 7'(c - 8'h41);
    if (c >= 8'h61 && c <= 8'h7A) return 7'(c - 8'h61 + 8'd26);
    if (c >= 8'h30 && c <= 8'h39) return 7'(c - 8'h30 + 8'd52);
    if (c == mdl_c62) return 7'd62;
    if (c == mdl_c63) return 7'd63;
    if (c == mdl_pad) return PAD_IDX;
    return BAD_IDX;
  endfunction

  task automatic clear_group();
    grp_bits = '0;
    grp_cnt  = '0;
    grp_pads = '0;
  endtask

  task automatic push_expected(logic [7:0] d, logic l, logic e);
    codec_out_t item;
    item.data = d;
    item.last = l;
    item.err  = e;
    expected_out_q.push_back(item);
  endtask

  task automatic decode_fail(logic l);
    clear_group();
    grp_skip = !l;
    push_expected(8'h00, l, 1'b1);
  endtask

  task automatic predict_encode(logic [7:0] b, logic l);
    int n;
    logic [23:0] word;
    grp_bits = {grp_bits[15:0], b};
    n = grp_cnt + 1;
    if (n < 3 && !l) begin
      grp_cnt = 2'(n);
      return;
    end
    word = grp_bits << (8 * (3 - n));
    for (int k = 0; k < 4; k++) begin
      push_expected((k <= n) ? six_to_char(6'(word >> (18 - 6 * k))) : mdl_pad,
                    (k == 3) ? l : 1'b0, 1'b0);
    end
    clear_group();
  endtask

  task automatic predict_decode(logic [7:0] c, logic l);
    logic [6:0] idx;
    int pos;
    int nb;
    idx = char_to_six(c);
    pos = grp_cnt;
    if (idx == BAD_IDX) begin
      decode_fail(l);
      return;
    end
    if (idx == PAD_IDX) begin
      if (pos < 2) begin
        decode_fail(l);
        return;
      end
      grp_pads = grp_pads + 2'd1;
      idx = '0;
    end else if (grp_pads != 2'd0) begin
      // data character after a pad
      decode_fail(l);
      return;
    end
    grp_bits = {grp_bits[17:0], idx[5:0]};
    if (pos < 3) begin
      if (l) begin
        decode_fail(l);
        return;
      end
      grp_cnt = 2'(pos + 1);
      return;
    end
    nb = 3 - grp_pads;
    for (int k = 0; k < nb; k++) begin
      push_expected(8'(grp_bits >> (16 - 8 * k)), (k + 1 == nb) ? l : 1'b0, 1'b0);
    end
    clear_group();
  endtask

  task automatic predict_transfer(logic [7:0] b, logic l);
    if (grp_skip) begin
      if (l) begin
        grp_skip = 1'b0;
        clear_group();
      end
      return;
    end
    if (mdl_dir == DIR_ENCODE) predict_encode(b, l);
    else predict_decode(b, l);
    if (l) clear_group();
  endtask

  task automatic model_config(logic [1:0] idx, logic [7:0] val);
    case (idx)
      REG_DIRECTION: begin
        mdl_dir = val[0];
        clear_group();
        grp_skip = 1'b0;
      end
      REG_CHAR_62: mdl_c62 = val;
      REG_CHAR_63: mdl_c63 = val;
      REG_PAD_CHAR: mdl_pad = val;
      default: ;
    endcase
  endtask

  // ---------------- drivers ----------------

  always @(negedge clk) begin
    rx_tick = rx_tick + 1;
    case (rx_mode)
      RX_ALWAYS: out_tready <= 1'b1;
      RX_RANDOM: out_tready <= ($urandom_range(0, 99) >= 40);
      default:   out_tready <= ((rx_tick % 7) < 4);
    endcase
  end

  task automatic send_item(logic [7:0] b, logic l);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
      burst_left = $urandom_range(1, 10);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    predict_transfer(b, l);
  endtask

  task automatic send_text(string s, bit with_last);
    for (int i = 0; i < s.len(); i++) send_item(s[i], with_last && (i == s.len() - 1));
  endtask

  // stop sending and wait for every pending result, then let the pipe settle
  task automatic drain_outputs(int settle);
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_out_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [7:0] val);
    drain_outputs(SETTLE_CYCLES);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
    model_config(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------- result checker ----------------

  always @(posedge clk) begin : result_check
    codec_out_t exp_item;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_out_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: data %h last %b err %b", out_tdata, out_tlast, out_tuser);
      end else begin
        exp_item = expected_out_q.pop_front();
        if (out_tdata !== exp_item.data || out_tlast !== exp_item.last ||
            out_tuser !== exp_item.err) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected data %h last %b err %b, got data %h last %b err %b",
                     exp_item.data, exp_item.last, exp_item.err,
                     out_tdata, out_tlast, out_tuser);
        end
      end
    end
  end

  // ---------------- tests ----------------

  task automatic test_encode_groups();
    // full group hitting both configurable symbols
    send_item(8'hFB, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hBF, 1'b1);
    // one byte, two pads
    send_item(8'h00, 1'b1);
    // two bytes, one pad
    send_item(8'h4D, 1'b0);
    send_item(8'h61, 1'b1);
  endtask

  task automatic test_decode_groups();
    cfg_write(REG_DIRECTION, {7'd0, DIR_DECODE});
    // padded group mid-stream, then a second group with nonzero bits under pad
    send_text("TWE=", 1'b0);
    send_text("TR==", 1'b1);
    send_text("+/A9", 1'b1);
  endtask

  task automatic test_decode_errors();
    // bad character at the start, rest skipped up to last
    send_text("*Z9", 1'b1);
    // pad in first position
    send_text("=", 1'b1);
    // pad in second position
    send_text("A=", 1'b1);
    // data after pad
    send_text("TQ=A", 1'b1);
    // short final group
    send_text("TW", 1'b1);
  endtask

  task automatic test_direction_write();
    cfg_write(REG_DIRECTION, {7'd0, DIR_ENCODE});
    send_text("AB", 1'b0);
    // half-built group must be dropped by the mode change
    cfg_write(REG_DIRECTION, {7'd0, DIR_DECODE});
    send_text("*", 1'b0);
    // rewriting the mode also leaves skip state
    cfg_write(REG_DIRECTION, {7'd0, DIR_DECODE});
    send_text("QQ==", 1'b1);
  endtask

  task automatic test_custom_symbols();
    cfg_write(REG_CHAR_62, 8'h2D);
    cfg_write(REG_CHAR_63, 8'h5F);
    cfg_write(REG_PAD_CHAR, 8'h2E);
    cfg_write(REG_DIRECTION, {7'd0, DIR_ENCODE});
    send_item(8'hFB, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hBF, 1'b1);
    cfg_write(REG_DIRECTION, {7'd0, DIR_DECODE});
    send_text("-_A.", 1'b1);
  endtask

  function automatic logic [7:0] pick_symbol();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(0, 255));
      1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      2: begin
        case ($urandom_range(0, 3))
          0: return 8'h2D;
          1: return 8'h5F;
          2: return 8'h2E;
          default: return 8'h7E;
        endcase
      end
      // drawn from 'A' to 'z' or the digits, mostly colliding with a fixed letter or digit
      default: return $urandom_range(0, 1) ? 8'($urandom_range(8'h41, 8'h7A))
                                           : 8'($urandom_range(8'h30, 8'h39));
    endcase
  endfunction

  task automatic test_random_traffic();
    logic [7:0]  c62, c63, cpad;
    logic        dir;
    logic [7:0]  chars[$];
    logic [23:0] w;
    int phase_items, nb, m, pos, kind;
    bit paused;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0, 1: begin
          c62 = 8'h00; c63 = 8'hFF; cpad = 8'h80;
        end
        2: begin
          c62 = 8'h2D; c63 = 8'h5F; cpad = 8'h2E;
        end
        default: begin
          c62 = pick_symbol(); c63 = pick_symbol(); cpad = pick_symbol();
        end
      endcase
      dir = (phase < 4) ? phase[0] : ($urandom_range(0, 2) != 0);
      cfg_write(REG_CHAR_62, c62);
      cfg_write(REG_CHAR_63, c63);
      cfg_write(REG_PAD_CHAR, cpad);
      cfg_write(REG_DIRECTION, {7'd0, dir});
      tx_gap_max = (phase == 0) ? 0 : $urandom_range(0, 5);
      rx_mode    = (phase == 0) ? RX_ALWAYS : $urandom_range(RX_ALWAYS, RX_PERIODIC);
      phase_items = 0;
      paused = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        chars.delete();
        if (mdl_dir == DIR_ENCODE) begin
          repeat ($urandom_range(1, 9)) chars.push_back(8'($urandom));
        end else begin
          kind = $urandom_range(0, 9);
          if (kind == 9) begin
            repeat ($urandom_range(1, 6)) chars.push_back(8'($urandom));
          end else begin
            // well-formed text of one or two chunks, each padded where its last group is short
            repeat ($urandom_range(1, 2)) begin
              nb = $urandom_range(1, 6);
              for (int i = 0; i < nb; i += 3) begin
                m = (nb - i < 3) ? nb - i : 3;
                w = 24'($urandom);
                if (m < 3) w[7:0] = 8'h00;
                if (m < 2) w[15:8] = 8'h00;
                for (int k = 0; k < 4; k++)
                  chars.push_back((k <= m) ? six_to_char(6'(w >> (18 - 6 * k))) : mdl_pad);
              end
            end
            if (kind >= 7) begin
              pos = $urandom_range(0, chars.size() - 1);
              case ($urandom_range(0, 2))
                0: chars[pos] = 8'($urandom);
                1: void'(chars.pop_back());
                default: chars[pos] = mdl_pad;
              endcase
            end
          end
        end
        foreach (chars[i]) send_item(chars[i], i == chars.size() - 1);
        phase_items += chars.size();
        if (!paused && phase_items >= ITEMS_PER_PHASE / 2) begin
          drain_outputs(0);
          paused = 1;
        end
      end
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 8'h00;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_DIRECTION;
    cfg_data   = 8'h00;
    mdl_dir    = DIR_ENCODE;
    mdl_c62    = CHAR_62_RST;
    mdl_c63    = CHAR_63_RST;
    mdl_pad    = PAD_CHAR_RST;
    grp_skip   = 1'b0;
    clear_group();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    tx_gap_max = 2;
    rx_mode    = RX_RANDOM;
    test_encode_groups();
    test_decode_groups();
    rx_mode    = RX_PERIODIC;
    test_decode_errors();
    test_direction_write();
    test_custom_symbols();
    test_random_traffic();

    drain_outputs(20);
    $display("run covered %0d input transfers, %0d results, %0d register writes",
             items_sent, results_seen, cfg_writes);
    $display("both directions, default and custom symbols, malformed decode streams");
    if (fail_count == 0 && expected_out_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d failures", fail_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/b64_pkg.sv
src/b64_fifo.sv
src/b64_front.sv
src/b64_back.sv
src/base64_stream_codec.sv
tb/tb_base64_stream_codec.sv
